// ----- rtl/spm_pkg.sv -----
`timescale 1ns / 1ps

package spm_pkg;

	localparam int MAX_TERMS_FIRST  = 8;
	localparam int MAX_TERMS_SECOND = 8;
	localparam int COEF_BITS        = 16;
	localparam int EXP_BITS         = 8;
	localparam int OUT_LIMIT        = 64;

	// port field widths
	localparam int IN_COEF_W  = 16;
	localparam int IN_EXP_W   = 8;
	localparam int OUT_COEF_W = 38;
	localparam int OUT_EXP_W  = 9;

	localparam int PROD_W    = 2 * COEF_BITS;
	localparam int SUM_EXP_W = EXP_BITS + 1;
	localparam int CNT_A_W   = $clog2(MAX_TERMS_FIRST + 1);
	localparam int CNT_B_W   = $clog2(MAX_TERMS_SECOND + 1);
	localparam int IDX_A_W   = (MAX_TERMS_FIRST > 1) ? $clog2(MAX_TERMS_FIRST) : 1;
	localparam int IDX_B_W   = (MAX_TERMS_SECOND > 1) ? $clog2(MAX_TERMS_SECOND) : 1;
	localparam int EMIT_W    = $clog2(OUT_LIMIT + 1);

	localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_MULTIPLY    = 2'd2;

	typedef struct packed {
		logic                 we;
		logic                 second;
		logic [COEF_BITS-1:0] coef;
		logic [EXP_BITS-1:0]  exp;
	} load_req_t;

	typedef struct packed {
		logic valid;
		logic start;
		logic last;
	} issue_t;

endpackage

// ----- rtl/spm_term_store.sv -----
`timescale 1ns / 1ps

module spm_term_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spm_pkg::load_req_t                 load,
	input  logic                               clear,
	input  logic [spm_pkg::IDX_A_W-1:0]        rd_a,
	input  logic [spm_pkg::IDX_B_W-1:0]        rd_b,
	output logic [spm_pkg::COEF_BITS-1:0]      coef_a,
	output logic [spm_pkg::EXP_BITS-1:0]       exp_a,
	output logic [spm_pkg::COEF_BITS-1:0]      coef_b,
	output logic [spm_pkg::EXP_BITS-1:0]       exp_b,
	output logic [spm_pkg::CNT_A_W-1:0]        count_a,
	output logic [spm_pkg::CNT_B_W-1:0]        count_b,
	output logic                               dropped
);

	logic [spm_pkg::COEF_BITS-1:0] coef_a_q [spm_pkg::MAX_TERMS_FIRST];
	logic [spm_pkg::EXP_BITS-1:0]  exp_a_q  [spm_pkg::MAX_TERMS_FIRST];
	logic [spm_pkg::COEF_BITS-1:0] coef_b_q [spm_pkg::MAX_TERMS_SECOND];
	logic [spm_pkg::EXP_BITS-1:0]  exp_b_q  [spm_pkg::MAX_TERMS_SECOND];
	logic [spm_pkg::CNT_A_W-1:0]   cnt_a_q;
	logic [spm_pkg::CNT_B_W-1:0]   cnt_b_q;
	logic                          drop_q;
	logic                          full_a;
	logic                          full_b;

	assign full_a = (cnt_a_q == spm_pkg::CNT_A_W'(spm_pkg::MAX_TERMS_FIRST));
	assign full_b = (cnt_b_q == spm_pkg::CNT_B_W'(spm_pkg::MAX_TERMS_SECOND));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			drop_q  <= 1'b0;
		end else if (clear) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			drop_q  <= 1'b0;
		end else if (load.we) begin
			if (!load.second) begin
				if (full_a) begin
					drop_q <= 1'b1;
				end else begin
					cnt_a_q <= cnt_a_q + spm_pkg::CNT_A_W'(1);
				end
			end else begin
				if (full_b) begin
					drop_q <= 1'b1;
				end else begin
					cnt_b_q <= cnt_b_q + spm_pkg::CNT_B_W'(1);
				end
			end
		end
	end

	// term payload, no reset
	always_ff @(posedge clk) begin
		if (load.we && !clear) begin
			if (!load.second && !full_a) begin
				coef_a_q[spm_pkg::IDX_A_W'(cnt_a_q)] <= load.coef;
				exp_a_q[spm_pkg::IDX_A_W'(cnt_a_q)]  <= load.exp;
			end
			if (load.second && !full_b) begin
				coef_b_q[spm_pkg::IDX_B_W'(cnt_b_q)] <= load.coef;
				exp_b_q[spm_pkg::IDX_B_W'(cnt_b_q)]  <= load.exp;
			end
		end
	end

	assign coef_a  = coef_a_q[rd_a];
	assign exp_a   = exp_a_q[rd_a];
	assign coef_b  = coef_b_q[rd_b];
	assign exp_b   = exp_b_q[rd_b];
	assign count_a = cnt_a_q;
	assign count_b = cnt_b_q;
	assign dropped = drop_q;

endmodule

// ----- rtl/spm_scan_unit.sv -----
`timescale 1ns / 1ps

// One pair per cycle: multiply and exponent add in stage 1; in stage 2 the product is
// summed when its exponent equals the target, and the smallest exponent above the
// target (any exponent, when there is no target yet) is tracked for the next pass.
module spm_scan_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spm_pkg::issue_t                    issue,
	input  logic [spm_pkg::COEF_BITS-1:0]      coef_a,
	input  logic [spm_pkg::EXP_BITS-1:0]       exp_a,
	input  logic [spm_pkg::COEF_BITS-1:0]      coef_b,
	input  logic [spm_pkg::EXP_BITS-1:0]       exp_b,
	input  logic                               have_target,
	input  logic [spm_pkg::SUM_EXP_W-1:0]      target,
	output logic                               done,
	output logic [spm_pkg::OUT_COEF_W-1:0]     sum,
	output logic                               next_found,
	output logic [spm_pkg::SUM_EXP_W-1:0]      next_exp
);

	spm_pkg::issue_t                     issue_s1;
	logic signed [spm_pkg::PROD_W-1:0]   prod_s1;
	logic [spm_pkg::SUM_EXP_W-1:0]       exp_s1;

	logic [spm_pkg::OUT_COEF_W-1:0]      acc_q;
	logic [spm_pkg::SUM_EXP_W-1:0]       min_q;
	logic                                found_q;
	logic                                done_q;

	logic [spm_pkg::OUT_COEF_W-1:0]      acc_base;
	logic [spm_pkg::OUT_COEF_W-1:0]      addend;
	logic [spm_pkg::SUM_EXP_W-1:0]       min_base;
	logic                                found_base;
	logic                                cand;
	logic                                take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
		end else begin
			issue_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(coef_a) * $signed(coef_b);
		exp_s1  <= spm_pkg::SUM_EXP_W'(exp_a) + spm_pkg::SUM_EXP_W'(exp_b);
	end

	always_comb begin
		acc_base   = issue_s1.start ? '0 : acc_q;
		min_base   = min_q;
		found_base = issue_s1.start ? 1'b0 : found_q;
		addend     = (have_target && exp_s1 == target) ?
			spm_pkg::OUT_COEF_W'(prod_s1) : '0;
		cand       = !have_target || (exp_s1 > target);
		take       = cand && (!found_base || exp_s1 < min_base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= issue_s1.valid && issue_s1.last;
			if (issue_s1.valid) begin
				found_q <= found_base || take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_s1.valid) begin
			acc_q <= acc_base + addend;
			min_q <= take ? exp_s1 : min_base;
		end
	end

	assign done       = done_q;
	assign sum        = acc_q;
	assign next_found = found_q;
	assign next_exp   = min_q;

endmodule

// ----- rtl/sparse_polynomial_multiply_unit.sv -----
`timescale 1ns / 1ps

// channel   dir  tdata                                         tlast      tuser
// s_axis    in   [1:0] cmd [17:2] coef [25:18] exp             -          -
// m_axis    out  [37:0] coefficient [46:38] exponent           last_term  terms_dropped
//
// A multiply makes one pass over all F*S stored pairs per distinct product exponent,
// one pair a cycle through the shared multiplier, plus one pass to find the first
// exponent.
// The input is not ready from the multiply request until its last term is queued.
// Reset clears both term counts and the drop flag; a stalled output holds its term.
module sparse_polynomial_multiply_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // cmd[1:0], term_coefficient[17:2], term_exponent[25:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // product_coefficient[37:0], product_exponent[46:38]
	output logic        m_axis_tlast,  // last_term
	output logic        m_axis_tuser   // terms_dropped
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_STEP,
		ST_FINAL
	} state_t;

	state_t state_q;

	logic [1:0]                          in_cmd;
	logic [spm_pkg::IN_COEF_W-1:0]       in_coef;
	logic [spm_pkg::IN_EXP_W-1:0]        in_exp;
	logic                                in_acc;
	spm_pkg::load_req_t                  load;
	spm_pkg::issue_t                     issue;
	logic                                store_clr;

	logic [spm_pkg::IDX_A_W-1:0]         i_q;
	logic [spm_pkg::IDX_B_W-1:0]         j_q;
	logic [spm_pkg::COEF_BITS-1:0]       coef_a;
	logic [spm_pkg::EXP_BITS-1:0]        exp_a;
	logic [spm_pkg::COEF_BITS-1:0]       coef_b;
	logic [spm_pkg::EXP_BITS-1:0]        exp_b;
	logic [spm_pkg::CNT_A_W-1:0]         cnt_a;
	logic [spm_pkg::CNT_B_W-1:0]         cnt_b;
	logic                                dropped;
	logic                                i_last;
	logic                                j_last;

	logic                                have_target_q;
	logic [spm_pkg::SUM_EXP_W-1:0]       target_q;
	logic                                scan_done;
	logic [spm_pkg::OUT_COEF_W-1:0]      scan_sum;
	logic                                next_found;
	logic [spm_pkg::SUM_EXP_W-1:0]       next_exp;

	logic                                pend_valid_q;
	logic [spm_pkg::OUT_COEF_W-1:0]      pend_coef_q;
	logic [spm_pkg::SUM_EXP_W-1:0]       pend_exp_q;
	logic [spm_pkg::EMIT_W-1:0]          emit_cnt_q;

	logic                                out_valid_q;
	logic [spm_pkg::OUT_COEF_W-1:0]      out_coef_q;
	logic [spm_pkg::OUT_EXP_W-1:0]       out_exp_q;
	logic                                out_last_q;
	logic                                out_drop_q;
	logic                                out_free;
	logic                                out_load;
	logic                                sum_nz;
	logic                                step_stall;
	logic                                emit_full;

	assign in_cmd  = s_axis_tdata[1:0];
	assign in_coef = s_axis_tdata[17:2];
	assign in_exp  = s_axis_tdata[25:18];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		load.we     = in_acc && (in_cmd == spm_pkg::CMD_LOAD_FIRST ||
			in_cmd == spm_pkg::CMD_LOAD_SECOND);
		load.second = (in_cmd == spm_pkg::CMD_LOAD_SECOND);
		load.coef   = spm_pkg::COEF_BITS'($signed(in_coef));
		load.exp    = spm_pkg::EXP_BITS'(in_exp);
	end

	assign i_last = (spm_pkg::CNT_A_W'(i_q) == cnt_a - spm_pkg::CNT_A_W'(1));
	assign j_last = (spm_pkg::CNT_B_W'(j_q) == cnt_b - spm_pkg::CNT_B_W'(1));

	always_comb begin
		issue.valid = (state_q == ST_SCAN);
		issue.start = (i_q == '0) && (j_q == '0);
		issue.last  = i_last && j_last;
	end

	assign out_free   = !out_valid_q || m_axis_tready;
	assign store_clr  = (state_q == ST_FINAL) && out_free;
	assign sum_nz     = have_target_q && (scan_sum != '0);
	assign step_stall = sum_nz && pend_valid_q && !out_free;
	assign emit_full  = (emit_cnt_q == spm_pkg::EMIT_W'(spm_pkg::OUT_LIMIT - 1));
	assign out_load   = ((state_q == ST_STEP) && !step_stall && sum_nz && pend_valid_q) ||
		store_clr;

	spm_term_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.clear   (store_clr),
		.rd_a    (i_q),
		.rd_b    (j_q),
		.coef_a  (coef_a),
		.exp_a   (exp_a),
		.coef_b  (coef_b),
		.exp_b   (exp_b),
		.count_a (cnt_a),
		.count_b (cnt_b),
		.dropped (dropped)
	);

	spm_scan_unit u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.coef_a      (coef_a),
		.exp_a       (exp_a),
		.coef_b      (coef_b),
		.exp_b       (exp_b),
		.have_target (have_target_q),
		.target      (target_q),
		.done        (scan_done),
		.sum         (scan_sum),
		.next_found  (next_found),
		.next_exp    (next_exp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			have_target_q <= 1'b0;
			pend_valid_q  <= 1'b0;
			emit_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_cmd == spm_pkg::CMD_MULTIPLY) begin
						i_q           <= '0;
						j_q           <= '0;
						have_target_q <= 1'b0;
						pend_valid_q  <= 1'b0;
						emit_cnt_q    <= '0;
						// an empty list gives no products at all
						state_q <= (cnt_a == '0 || cnt_b == '0) ? ST_FINAL : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + spm_pkg::IDX_A_W'(1);
					end else begin
						j_q <= j_q + spm_pkg::IDX_B_W'(1);
					end
					if (issue.last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (scan_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!step_stall) begin
						if (sum_nz) begin
							// a held term goes out here only once a later one is known; the last goes out in ST_FINAL
							if (pend_valid_q) begin
								out_coef_q  <= pend_coef_q;
								out_exp_q   <= spm_pkg::OUT_EXP_W'(pend_exp_q);
								out_last_q  <= 1'b0;
								out_drop_q  <= dropped;
							end
							pend_valid_q <= 1'b1;
							pend_coef_q  <= scan_sum;
							pend_exp_q   <= target_q;
							emit_cnt_q   <= emit_cnt_q + spm_pkg::EMIT_W'(1);
						end
						if (next_found && !(sum_nz && emit_full)) begin
							target_q      <= next_exp;
							have_target_q <= 1'b1;
							state_q       <= ST_SCAN;
						end else begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						out_coef_q   <= pend_valid_q ? pend_coef_q : '0;
						out_exp_q    <= pend_valid_q ? spm_pkg::OUT_EXP_W'(pend_exp_q) : '0;
						out_last_q   <= 1'b1;
						out_drop_q   <= dropped;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_exp_q, out_coef_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_drop_q;

	a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> !s_axis_tready)
		else $error("pair issued while input ready");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_WAIT))
		else $error("scan pass finished outside wait state");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a <= spm_pkg::CNT_A_W'(spm_pkg::MAX_TERMS_FIRST)) &&
		(cnt_b <= spm_pkg::CNT_B_W'(spm_pkg::MAX_TERMS_SECOND)))
		else $error("term count beyond capacity");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		store_clr |=> (cnt_a == '0 && cnt_b == '0 && !dropped && m_axis_tvalid &&
			m_axis_tlast))
		else $error("final term without list clear");

endmodule
